[rtl/dlr_pkg.sv]
// ----------------------------------------------------------------------------
// dlr_pkg
// shared constants, types and lookup functions of the downmix resampler
// ----------------------------------------------------------------------------
package dlr_pkg;

    localparam int MAX_CHANNELS    = 8;
    localparam int WINDOW_SIZE     = 1024;
    localparam int PHASE_FRAC_BITS = 24;
    localparam int MAX_OUT         = 6;

    localparam int SAMPLE_W   = 24;
    localparam int CHAN_W     = 4;
    localparam int PHASE_W    = 27;
    localparam int CFG_DATA_W = 27;
    localparam int CFG_IDX_W  = 1;

    // phase accumulator carries one bit above the increment width
    localparam int ACC_W      = PHASE_W + 1;

    localparam int SUM_W       = SAMPLE_W + $clog2(MAX_CHANNELS);
    localparam int MAG_W       = SUM_W;
    localparam int RECIP_SHIFT = SUM_W + $clog2(MAX_CHANNELS);
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int DIV_PROD_W  = MAG_W + RECIP_W;

    localparam int DIFF_W      = SAMPLE_W + 1;
    localparam int INT_PROD_W  = 2 * DIFF_W;
    localparam int WPOS_W      = $clog2(WINDOW_SIZE);
    localparam int OCNT_W      = $clog2(MAX_OUT + 1);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(64'd1 << PHASE_FRAC_BITS);
    localparam logic [WPOS_W-1:0]  WPOS_LAST = WPOS_W'(WINDOW_SIZE - 1);

    localparam logic [CHAN_W-1:0]  CHANNEL_COUNT_RESET   = CHAN_W'(2);
    localparam logic [PHASE_W-1:0] PHASE_INCREMENT_RESET = PHASE_W'(16777216);

    localparam longint unsigned RECIP_ONE = 64'd1 << RECIP_SHIFT;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_INCREMENT = CFG_IDX_W'(1);

    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] mono;
    } t_push;

    typedef struct packed {
        logic                       avail;
        logic signed [SAMPLE_W-1:0] mono;
    } t_q_out;

    typedef struct packed {
        logic               restart;
        logic [PHASE_W-1:0] phase_inc;
    } t_cfg;

    function automatic logic [CHAN_W-1:0] clamp_nch(input logic [CHAN_W-1:0] cc);
        logic [CHAN_W-1:0] n;
        n = cc;
        if (cc == '0) begin
            n = CHAN_W'(1);
        end else if (cc > CHAN_W'(MAX_CHANNELS)) begin
            n = CHAN_W'(MAX_CHANNELS);
        end
        return n;
    endfunction

    // ceil(2^RECIP_SHIFT / n), exact quotient for every reachable sum
    function automatic logic [RECIP_W-1:0] recip(input logic [CHAN_W-1:0] n);
        logic [RECIP_W-1:0] r;
        case (n)
            4'd1:    r = RECIP_W'(RECIP_ONE);
            4'd2:    r = RECIP_W'(RECIP_ONE / 64'd2);
            4'd3:    r = RECIP_W'((RECIP_ONE + 64'd2) / 64'd3);
            4'd4:    r = RECIP_W'(RECIP_ONE / 64'd4);
            4'd5:    r = RECIP_W'((RECIP_ONE + 64'd4) / 64'd5);
            4'd6:    r = RECIP_W'((RECIP_ONE + 64'd5) / 64'd6);
            4'd7:    r = RECIP_W'((RECIP_ONE + 64'd6) / 64'd7);
            4'd8:    r = RECIP_W'(RECIP_ONE / 64'd8);
            default: r = RECIP_W'(RECIP_ONE);
        endcase
        return r;
    endfunction

endpackage

[rtl/dlr_if.sv]
// ----------------------------------------------------------------------------
// dlr_if
// valid/ready channels for multichannel frames and mono output samples
// ----------------------------------------------------------------------------
interface dlr_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [dlr_pkg::SAMPLE_W-1:0] chan0_sample;
    logic signed [dlr_pkg::SAMPLE_W-1:0] chan1_sample;
    logic signed [dlr_pkg::SAMPLE_W-1:0] chan2_sample;
    logic signed [dlr_pkg::SAMPLE_W-1:0] chan3_sample;
    logic signed [dlr_pkg::SAMPLE_W-1:0] chan4_sample;
    logic signed [dlr_pkg::SAMPLE_W-1:0] chan5_sample;
    logic signed [dlr_pkg::SAMPLE_W-1:0] chan6_sample;
    logic signed [dlr_pkg::SAMPLE_W-1:0] chan7_sample;

    modport source (
        output valid, chan0_sample, chan1_sample, chan2_sample, chan3_sample,
               chan4_sample, chan5_sample, chan6_sample, chan7_sample,
        input  ready
    );
    modport sink (
        input  valid, chan0_sample, chan1_sample, chan2_sample, chan3_sample,
               chan4_sample, chan5_sample, chan6_sample, chan7_sample,
        output ready
    );
endinterface

interface dlr_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [dlr_pkg::SAMPLE_W-1:0] mono_out;
    logic                                window_end;

    modport source (output valid, mono_out, window_end, input ready);
    modport sink   (input valid, mono_out, window_end, output ready);
endinterface

[rtl/downmix_linear_resampler.sv]
// ----------------------------------------------------------------------------
// downmix_linear_resampler
// averages the active channels of each frame to mono and resamples the mono
// stream by linear interpolation with a carried fixed-point phase
// path: an accepted frame goes via F_MUL and F_PUSH (held while the queue is full)
//   into the queue, and the front takes no new frame until then; the interpolator
//   forms each of up to 6 samples per frame via B_CHECK and B_EMIT, held on a stall
// reset: synchronous active low; clears state, config to its defaults
// ----------------------------------------------------------------------------
module downmix_linear_resampler (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    dlr_in_if.sink                            i_frame,
    dlr_out_if.source                         o_mono,
    input  logic                              i_cfg_we,
    input  logic [dlr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dlr_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic [dlr_pkg::CHAN_W-1:0]  r_channel_count;
    logic [dlr_pkg::PHASE_W-1:0] r_phase_increment;
    logic                        w_idx_ok;
    logic                        w_q_full;
    logic                        w_pop;
    dlr_pkg::t_push              w_push;
    dlr_pkg::t_q_out             w_q_out;
    dlr_pkg::t_cfg               w_cfg;

    always_comb begin
        case (i_cfg_index)
            dlr_pkg::REG_CHANNEL_COUNT:   w_idx_ok = 1'b1;
            dlr_pkg::REG_PHASE_INCREMENT: w_idx_ok = 1'b1;
            default:                      w_idx_ok = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count   <= dlr_pkg::CHANNEL_COUNT_RESET;
            r_phase_increment <= dlr_pkg::PHASE_INCREMENT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dlr_pkg::REG_CHANNEL_COUNT: begin
                    r_channel_count <= i_cfg_data[dlr_pkg::CHAN_W-1:0];
                end
                dlr_pkg::REG_PHASE_INCREMENT: begin
                    r_phase_increment <= i_cfg_data[dlr_pkg::PHASE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign w_cfg.restart   = i_cfg_we && w_idx_ok;
    assign w_cfg.phase_inc = r_phase_increment;

    dlr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_frame         (i_frame),
        .i_channel_count (r_channel_count),
        .i_q_full        (w_q_full),
        .o_push          (w_push)
    );

    dlr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_out   (w_q_out)
    );

    dlr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (w_q_out),
        .o_pop   (w_pop),
        .i_cfg   (w_cfg),
        .o_mono  (o_mono)
    );

endmodule

[rtl/dlr_front.sv]
// ----------------------------------------------------------------------------
// dlr_front
// accepts frames, sums the active channels and divides by the channel count
// ----------------------------------------------------------------------------
module dlr_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    dlr_in_if.sink                         i_frame,
    input  logic [dlr_pkg::CHAN_W-1:0]     i_channel_count,
    input  logic                           i_q_full,
    output dlr_pkg::t_push                 o_push
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_MUL  = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate r_state, n_state;

    logic signed [dlr_pkg::SAMPLE_W-1:0]   w_chan [dlr_pkg::MAX_CHANNELS];
    logic [dlr_pkg::CHAN_W-1:0]            w_nch;
    logic signed [dlr_pkg::SUM_W-1:0]      w_sum;
    logic [dlr_pkg::MAG_W-1:0]             w_mag;
    logic [dlr_pkg::MAG_W-1:0]             w_q;
    logic                                  w_accept;

    logic [dlr_pkg::MAG_W-1:0]             r_mag;
    logic                                  r_neg;
    logic [dlr_pkg::DIV_PROD_W-1:0]        r_prod;

    assign w_chan[0] = i_frame.chan0_sample;
    assign w_chan[1] = i_frame.chan1_sample;
    assign w_chan[2] = i_frame.chan2_sample;
    assign w_chan[3] = i_frame.chan3_sample;
    assign w_chan[4] = i_frame.chan4_sample;
    assign w_chan[5] = i_frame.chan5_sample;
    assign w_chan[6] = i_frame.chan6_sample;
    assign w_chan[7] = i_frame.chan7_sample;

    assign w_nch = dlr_pkg::clamp_nch(i_channel_count);

    always_comb begin
        w_sum = '0;
        for (int c = 0; c < dlr_pkg::MAX_CHANNELS; c++) begin
            if (c < int'(w_nch)) begin
                w_sum = w_sum + dlr_pkg::SUM_W'(w_chan[c]);
            end
        end
        w_mag = w_sum[dlr_pkg::SUM_W-1] ? dlr_pkg::MAG_W'(-w_sum) : dlr_pkg::MAG_W'(w_sum);
    end

    assign i_frame.ready = (r_state == F_IDLE);
    assign w_accept      = i_frame.valid && (r_state == F_IDLE);

    assign w_q         = r_prod[dlr_pkg::RECIP_SHIFT +: dlr_pkg::MAG_W];
    assign o_push.valid = (r_state == F_PUSH) && !i_q_full;
    assign o_push.mono  = r_neg ? dlr_pkg::SAMPLE_W'(-w_q) : dlr_pkg::SAMPLE_W'(w_q);

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (w_accept) begin
                    n_state = F_MUL;
                end
            end
            F_MUL: begin
                n_state = F_PUSH;
            end
            F_PUSH: begin
                if (!i_q_full) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mag <= w_mag;
            r_neg <= w_sum[dlr_pkg::SUM_W-1];
        end
        if (r_state == F_MUL) begin
            r_prod <= dlr_pkg::DIV_PROD_W'(r_mag) * dlr_pkg::DIV_PROD_W'(dlr_pkg::recip(w_nch));
        end
    end

endmodule

[rtl/dlr_queue.sv]
// ----------------------------------------------------------------------------
// dlr_queue
// short fifo of mono samples between the downmix and the interpolator
// ----------------------------------------------------------------------------
module dlr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dlr_pkg::t_push  i_push,
    input  logic            i_pop,
    output logic            o_full,
    output dlr_pkg::t_q_out o_out
);

    logic signed [dlr_pkg::SAMPLE_W-1:0] r_mem [dlr_pkg::QDEPTH];
    logic [dlr_pkg::QPTR_W-1:0]          r_wr;
    logic [dlr_pkg::QPTR_W-1:0]          r_rd;
    logic [dlr_pkg::QCNT_W-1:0]          r_cnt;
    logic                                w_pop;

    assign o_full      = (r_cnt == dlr_pkg::QCNT_W'(dlr_pkg::QDEPTH));
    assign o_out.avail = (r_cnt != '0);
    assign o_out.mono  = r_mem[r_rd];
    assign w_pop       = i_pop && o_out.avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr <= (r_wr == dlr_pkg::QPTR_W'(dlr_pkg::QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == dlr_pkg::QPTR_W'(dlr_pkg::QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push.valid && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !i_push.valid) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.mono;
        end
    end

endmodule

[rtl/dlr_back.sv]
// ----------------------------------------------------------------------------
// dlr_back
// linear interpolator with carried phase, window counter and output register
// ----------------------------------------------------------------------------
module dlr_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dlr_pkg::t_q_out i_q,
    output logic            o_pop,
    input  dlr_pkg::t_cfg   i_cfg,
    dlr_out_if.source       o_mono
);

    typedef enum logic [2:0] {
        B_IDLE  = 3'b001,
        B_CHECK = 3'b010,
        B_EMIT  = 3'b100
    } t_bstate;

    t_bstate r_state;

    logic signed [dlr_pkg::SAMPLE_W-1:0]   r_prior;
    logic                                  r_have;
    logic [dlr_pkg::ACC_W-1:0]             r_phase;
    logic [dlr_pkg::WPOS_W-1:0]            r_wpos;
    logic signed [dlr_pkg::SAMPLE_W-1:0]   r_cur;
    logic signed [dlr_pkg::DIFF_W-1:0]     r_diff;
    logic signed [dlr_pkg::INT_PROD_W-1:0] r_prod;
    logic [dlr_pkg::OCNT_W-1:0]            r_cnt;
    logic                                  r_ovalid;
    logic signed [dlr_pkg::SAMPLE_W-1:0]   r_omono;
    logic                                  r_owin;

    logic signed [dlr_pkg::DIFF_W-1:0]     w_frac;
    logic signed [dlr_pkg::INT_PROD_W-1:0] w_y;
    logic                                  w_more;
    logic                                  w_emit;

    assign o_mono.valid      = r_ovalid;
    assign o_mono.mono_out   = r_omono;
    assign o_mono.window_end = r_owin;

    assign o_pop  = (r_state == B_IDLE) && i_q.avail;
    assign w_frac = signed'({1'b0, r_phase[dlr_pkg::PHASE_FRAC_BITS-1:0]});
    assign w_more = (r_phase < dlr_pkg::ACC_W'(dlr_pkg::PHASE_ONE)) &&
                    (r_cnt < dlr_pkg::OCNT_W'(dlr_pkg::MAX_OUT));
    assign w_emit = (r_state == B_EMIT) && (!r_ovalid || o_mono.ready);
    assign w_y    = dlr_pkg::INT_PROD_W'(r_prior) + (r_prod >>> dlr_pkg::PHASE_FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_prior  <= '0;
            r_have   <= 1'b0;
            r_phase  <= '0;
            r_wpos   <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (o_mono.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (o_pop) begin
                        if (!r_have) begin
                            r_prior <= i_q.mono;
                            r_have  <= 1'b1;
                        end else begin
                            r_cur   <= i_q.mono;
                            r_diff  <= dlr_pkg::DIFF_W'(i_q.mono) - dlr_pkg::DIFF_W'(r_prior);
                            r_cnt   <= '0;
                            r_state <= B_CHECK;
                        end
                    end
                end
                B_CHECK: begin
                    if (w_more) begin
                        r_prod  <= r_diff * w_frac;
                        r_state <= B_EMIT;
                    end else begin
                        r_phase <= (r_phase >= dlr_pkg::ACC_W'(dlr_pkg::PHASE_ONE)) ?
                                   r_phase - dlr_pkg::ACC_W'(dlr_pkg::PHASE_ONE) : '0;
                        r_prior <= r_cur;
                        r_state <= B_IDLE;
                    end
                end
                B_EMIT: begin
                    if (w_emit) begin
                        r_omono <= w_y[dlr_pkg::SAMPLE_W-1:0];
                        r_owin  <= (r_wpos == dlr_pkg::WPOS_LAST);
                        r_wpos  <= (r_wpos == dlr_pkg::WPOS_LAST) ? '0 : r_wpos + 1'b1;
                        r_cnt   <= r_cnt + 1'b1;
                        r_phase <= r_phase + dlr_pkg::ACC_W'(i_cfg.phase_inc);
                        r_state <= B_CHECK;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
            if (i_cfg.restart) begin
                r_phase <= '0;
                r_have  <= 1'b0;
            end
        end
    end

endmodule

[rtl/dlr_checker.sv]
// ----------------------------------------------------------------------------
// dlr_checker
// port-level checks of the output channel and the window flag spacing
// ----------------------------------------------------------------------------
module dlr_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [dlr_pkg::SAMPLE_W-1:0] i_out_mono,
    input  logic                                i_out_win
);

    logic [dlr_pkg::WPOS_W-1:0] r_seen;

    // count delivered items modulo the window length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (i_out_valid && i_out_ready) begin
            r_seen <= (r_seen == dlr_pkg::WPOS_LAST) ? '0 : r_seen + 1'b1;
        end
    end

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_mono) && $stable(i_out_win))
        else $error("output payload changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_window_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready |-> (i_out_win == (r_seen == dlr_pkg::WPOS_LAST)))
        else $error("window end flag at wrong position");

endmodule

bind downmix_linear_resampler dlr_checker u_dlr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_mono.valid),
    .i_out_ready (o_mono.ready),
    .i_out_mono  (o_mono.mono_out),
    .i_out_win   (o_mono.window_end)
);

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the downmix resampler: frames go in through the
// valid/ready input channel, each accepted frame is run through an internal
// model of the downmix and linear interpolator, and every output sample is
// compared in order against the model's queue. a short table of directed
// frames comes first, then random frames under several register settings
// and idling patterns on both channels.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int ITEMS_PER_PASS = 36;
    localparam int PASSES         = 8;
    localparam int MAX_PRINTS     = 100;

    localparam longint unsigned PHASE_UNITY = 64'd1 << dlr_pkg::PHASE_FRAC_BITS;
    localparam int unsigned     INC_LOW     = 3043485;
    localparam int unsigned     INC_HIGH    = 83886080;

    localparam int SEND_IDLE_PCT [4] = '{0, 86, 0, 9};
    localparam int STALL_PCT     [4] = '{0, 0, 86, 9};

    typedef logic signed [dlr_pkg::SAMPLE_W-1:0]                   t_sample;
    typedef logic [dlr_pkg::MAX_CHANNELS-1:0][dlr_pkg::SAMPLE_W-1:0] t_frame;

    localparam t_sample S_MAX = 24'sh7FFFFF;
    localparam t_sample S_MIN = 24'sh800000;

    typedef struct packed {
        logic signed [dlr_pkg::SAMPLE_W-1:0] mono;
        logic                                wend;
    } t_mono_res;

    typedef enum logic [1:0] {
        BY_MODEL,
        TYPED_NONE,
        TYPED_ONE
    } t_check_kind;

    typedef struct packed {
        logic                           is_cfg;
        logic [dlr_pkg::CFG_IDX_W-1:0]  cfg_index;
        logic [dlr_pkg::CFG_DATA_W-1:0] cfg_value;
        t_frame                         frame;
        t_check_kind                    kind;
        t_mono_res                      want;
    } t_stim_row;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [dlr_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [dlr_pkg::CFG_DATA_W-1:0] cfg_data;

    dlr_in_if  frame_if ();
    dlr_out_if mono_if ();

    downmix_linear_resampler dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_frame     (frame_if),
        .o_mono      (mono_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // model state
    logic [dlr_pkg::CHAN_W-1:0]  m_chan_count;
    logic [dlr_pkg::PHASE_W-1:0] m_phase_inc;
    longint             m_prior;
    bit                 m_primed;
    longint unsigned    m_phase;
    int                 m_wpos;

    t_mono_res   pending_samples [$];
    t_mono_res   fresh_samples [$];
    t_stim_row   stim_table [$];

    int error_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_req = 0;
    int hold_left = 0;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** downmix_linear_resampler: FAILED **");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTS) begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
        error_count++;
    endtask

    // downmix one frame and interpolate, results land in fresh_samples
    task automatic downmix_interp(input t_frame f);
        int unsigned nch;
        longint      sum;
        longint      mono;
        longint      diff;
        longint      y;
        bit          flag;
        t_mono_res   res;
        fresh_samples.delete();
        nch = m_chan_count;
        if (nch < 1) begin
            nch = 1;
        end else if (nch > dlr_pkg::MAX_CHANNELS) begin
            nch = dlr_pkg::MAX_CHANNELS;
        end
        sum = 0;
        for (int c = 0; c < int'(nch); c++) begin
            sum += longint'($signed(f[c]));
        end
        mono = sum / longint'(nch);
        if (!m_primed) begin
            m_prior  = mono;
            m_primed = 1'b1;
            return;
        end
        while (m_phase < PHASE_UNITY && fresh_samples.size() < dlr_pkg::MAX_OUT) begin
            diff = mono - m_prior;
            y    = m_prior + ((diff * longint'(m_phase)) >>> dlr_pkg::PHASE_FRAC_BITS);
            flag = (m_wpos == dlr_pkg::WINDOW_SIZE - 1);
            m_wpos = flag ? 0 : m_wpos + 1;
            res.mono = y[dlr_pkg::SAMPLE_W-1:0];
            res.wend = flag;
            fresh_samples.insert(fresh_samples.size(), res);
            m_phase += m_phase_inc;
        end
        m_phase = (m_phase >= PHASE_UNITY) ? m_phase - PHASE_UNITY : 64'd0;
        m_prior = mono;
    endtask

    // drop valid and wait for the block to go quiet
    task automatic settle();
        frame_if.valid <= 1'b0;
        while (pending_samples.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_setting(input logic [dlr_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [dlr_pkg::CFG_DATA_W-1:0] val);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == dlr_pkg::REG_CHANNEL_COUNT) begin
            m_chan_count = val[dlr_pkg::CHAN_W-1:0];
        end else if (idx == dlr_pkg::REG_PHASE_INCREMENT) begin
            m_phase_inc = val[dlr_pkg::PHASE_W-1:0];
        end
        m_phase  = 0;
        m_primed = 1'b0;
    endtask

    task automatic send_frame(input t_frame f, input t_check_kind kind,
                              input t_mono_res want);
        while ($urandom_range(99) < send_idle_pct) begin
            frame_if.valid <= 1'b0;
            @(posedge clk);
        end
        frame_if.valid        <= 1'b1;
        frame_if.chan0_sample <= f[0];
        frame_if.chan1_sample <= f[1];
        frame_if.chan2_sample <= f[2];
        frame_if.chan3_sample <= f[3];
        frame_if.chan4_sample <= f[4];
        frame_if.chan5_sample <= f[5];
        frame_if.chan6_sample <= f[6];
        frame_if.chan7_sample <= f[7];
        @(posedge clk);
        while (!frame_if.ready) begin
            @(posedge clk);
        end
        downmix_interp(f);
        if (kind == BY_MODEL) begin
            foreach (fresh_samples[i]) begin
                pending_samples.insert(pending_samples.size(), fresh_samples[i]);
            end
        end else if (kind == TYPED_ONE) begin
            pending_samples.insert(pending_samples.size(), want);
        end
    endtask

    task automatic add_row(input t_stim_row r);
        stim_table.insert(stim_table.size(), r);
    endtask

    function automatic t_frame random_frame();
        t_frame f;
        for (int c = 0; c < dlr_pkg::MAX_CHANNELS; c++) begin
            case ($urandom_range(15))
                0:       f[c] = S_MAX;
                1:       f[c] = S_MIN;
                2:       f[c] = '0;
                3:       f[c] = '1;
                4:       f[c] = dlr_pkg::SAMPLE_W'($urandom_range(511)) -
                                dlr_pkg::SAMPLE_W'(256);
                default: f[c] = dlr_pkg::SAMPLE_W'($urandom());
            endcase
        end
        return f;
    endfunction

    function automatic t_stim_row frame_row(input t_sample a, input t_sample b,
                                            input t_sample rest,
                                            input t_check_kind kind = BY_MODEL,
                                            input t_sample y = '0);
        t_stim_row r;
        r = '0;
        r.frame[0] = a;
        r.frame[1] = b;
        for (int c = 2; c < dlr_pkg::MAX_CHANNELS; c++) begin
            r.frame[c] = rest;
        end
        r.kind = kind;
        r.want = '{mono: y, wend: 1'b0};
        return r;
    endfunction

    function automatic t_stim_row cfg_row(input logic [dlr_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [dlr_pkg::CFG_DATA_W-1:0] val);
        t_stim_row r;
        r = '0;
        r.is_cfg    = 1'b1;
        r.cfg_index = idx;
        r.cfg_value = val;
        return r;
    endfunction

    // output side: check each accepted sample and drive ready
    initial begin
        t_mono_res want;
        forever begin
            @(posedge clk);
            if (rst_n && mono_if.valid && mono_if.ready) begin
                if (pending_samples.size() == 0) begin
                    report_mismatch($sformatf("unexpected sample %0d",
                                              mono_if.mono_out));
                end else begin
                    want = pending_samples.pop_front();
                    if (mono_if.mono_out !== want.mono) begin
                        report_mismatch($sformatf("mono_out %0d, want %0d",
                                                  mono_if.mono_out, want.mono));
                    end
                    if (mono_if.window_end !== want.wend) begin
                        report_mismatch($sformatf("window_end %0b, want %0b",
                                                  mono_if.window_end, want.wend));
                    end
                end
            end
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                mono_if.ready <= 1'b0;
            end else begin
                mono_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin
        t_frame                         f;
        logic [dlr_pkg::CFG_DATA_W-1:0] val;
        int                             mode;

        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_index             <= '0;
        cfg_data              <= '0;
        frame_if.valid        <= 1'b0;
        frame_if.chan0_sample <= '0;
        frame_if.chan1_sample <= '0;
        frame_if.chan2_sample <= '0;
        frame_if.chan3_sample <= '0;
        frame_if.chan4_sample <= '0;
        frame_if.chan5_sample <= '0;
        frame_if.chan6_sample <= '0;
        frame_if.chan7_sample <= '0;
        mono_if.ready         <= 1'b0;

        m_chan_count = dlr_pkg::CHANNEL_COUNT_RESET;
        m_phase_inc  = dlr_pkg::PHASE_INCREMENT_RESET;
        m_prior      = 0;
        m_primed     = 1'b0;
        m_phase      = 0;
        m_wpos       = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset: two channels, unity increment, phase at zero
        add_row(frame_row(24'sd100, 24'sd300, '0, TYPED_NONE));
        add_row(frame_row(S_MAX, S_MAX, '0, TYPED_ONE, 24'sd200));
        add_row(frame_row(S_MIN, S_MIN, '0, TYPED_ONE, S_MAX));
        add_row(frame_row(S_MAX, S_MIN, '0, TYPED_ONE, S_MIN));
        // average truncates toward zero
        add_row(frame_row(-24'sd3, '0, '0, TYPED_ONE, '0));
        add_row(frame_row('0, '0, '0, TYPED_ONE, -24'sd1));
        add_row(cfg_row(dlr_pkg::REG_CHANNEL_COUNT, 27'd3));
        add_row(frame_row(S_MAX, S_MAX, S_MAX, TYPED_NONE));
        add_row(frame_row(-24'sd7, -24'sd1, '0, TYPED_ONE, S_MAX));
        // zero channels acts as one
        add_row(cfg_row(dlr_pkg::REG_CHANNEL_COUNT, 27'd0));
        add_row(frame_row(24'sd5, S_MIN, S_MIN, TYPED_NONE));
        add_row(frame_row(S_MIN, S_MAX, S_MAX, TYPED_ONE, 24'sd5));
        // counts above the maximum act as eight
        add_row(cfg_row(dlr_pkg::REG_CHANNEL_COUNT, 27'd15));
        add_row(frame_row(S_MIN, S_MIN, S_MIN, TYPED_NONE));
        add_row(frame_row(S_MAX, S_MAX, S_MAX, TYPED_ONE, S_MIN));
        // half step interpolation
        add_row(cfg_row(dlr_pkg::REG_PHASE_INCREMENT, 27'd8388608));
        add_row(frame_row(24'sd1000, 24'sd3000, -24'sd5000));
        add_row(frame_row(S_MAX, S_MIN, 24'sd7));
        add_row(frame_row(-24'sd12345, 24'sd54321, S_MAX));
        // largest increment skips inputs
        add_row(cfg_row(dlr_pkg::REG_PHASE_INCREMENT, 27'h7FFFFFF));
        add_row(frame_row(24'sd10, 24'sd20, 24'sd30));
        add_row(frame_row(S_MAX, 24'sd20, 24'sd30));
        add_row(frame_row(S_MIN, S_MIN, 24'sd1));
        add_row(frame_row(24'sd77, -24'sd77, '0));
        // zero and tiny increments: six samples per frame, leftover phase cleared to zero
        add_row(cfg_row(dlr_pkg::REG_PHASE_INCREMENT, 27'd0));
        add_row(frame_row(24'sd4000, 24'sd4000, 24'sd4000));
        add_row(frame_row(S_MIN, S_MAX, -24'sd8));
        add_row(cfg_row(dlr_pkg::REG_PHASE_INCREMENT, 27'd1000));
        add_row(frame_row(S_MAX, S_MAX, S_MAX));
        add_row(frame_row(S_MIN, S_MIN, S_MIN));

        foreach (stim_table[i]) begin
            if (stim_table[i].is_cfg) begin
                write_setting(stim_table[i].cfg_index, stim_table[i].cfg_value);
            end else begin
                send_frame(stim_table[i].frame, stim_table[i].kind,
                           stim_table[i].want);
            end
        end

        for (int pass = 0; pass < PASSES; pass++) begin
            val = dlr_pkg::CFG_DATA_W'($urandom());
            case (pass)
                0:       val[dlr_pkg::CHAN_W-1:0] = dlr_pkg::CHAN_W'(1);
                1:       val[dlr_pkg::CHAN_W-1:0] = dlr_pkg::CHAN_W'(8);
                3:       val[dlr_pkg::CHAN_W-1:0] = dlr_pkg::CHAN_W'($urandom_range(15));
                6:       val[dlr_pkg::CHAN_W-1:0] = dlr_pkg::CHAN_W'(7);
                7:       val[dlr_pkg::CHAN_W-1:0] = dlr_pkg::CHAN_W'($urandom_range(15));
                default: val[dlr_pkg::CHAN_W-1:0] = dlr_pkg::CHAN_W'($urandom_range(1, 8));
            endcase
            write_setting(dlr_pkg::REG_CHANNEL_COUNT, val);
            case (pass)
                0:       val = dlr_pkg::CFG_DATA_W'(INC_LOW);
                1:       val = dlr_pkg::CFG_DATA_W'(INC_HIGH);
                2:       val = dlr_pkg::CFG_DATA_W'($urandom_range(INC_LOW, 6000000));
                4:       val = dlr_pkg::CFG_DATA_W'($urandom_range(INC_LOW, 4000000));
                6:       val = dlr_pkg::CFG_DATA_W'($urandom_range(INC_LOW, 3500000));
                7:       val = dlr_pkg::CFG_DATA_W'($urandom_range(INC_LOW, 20000000));
                default: val = dlr_pkg::CFG_DATA_W'($urandom_range(INC_LOW, INC_HIGH));
            endcase
            write_setting(dlr_pkg::REG_PHASE_INCREMENT, val);

            mode          = pass % 4;
            send_idle_pct = SEND_IDLE_PCT[mode];
            stall_pct     = STALL_PCT[mode];

            for (int n = 0; n < ITEMS_PER_PASS; n++) begin
                if (pass == 3 && n == 10) begin
                    // long output hold while frames keep coming
                    hold_req      = 400;
                    send_idle_pct = 0;
                    for (int k = 0; k < 24; k++) begin
                        f = random_frame();
                        send_frame(f, BY_MODEL, '0);
                    end
                    send_idle_pct = SEND_IDLE_PCT[mode];
                end
                if (pass == 5 && n == 20) begin
                    settle();
                end
                f = random_frame();
                send_frame(f, BY_MODEL, '0);
            end
        end

        send_idle_pct = 0;
        stall_pct     = 0;
        settle();

        if (error_count == 0) begin
            $display("** downmix_linear_resampler: PASSED **");
        end else begin
            $display("** downmix_linear_resampler: FAILED **");
        end
        $finish;
    end

endmodule
